@@ rtl/ecbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ecbb_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MAX_RADIUS = 7;

	localparam int X_W    = $clog2(MAX_WIDTH);
	localparam int Y_W    = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = X_W + Y_W;
	localparam int PIX_W  = 24;
	localparam int CH_W   = 8;
	localparam int RAD_W  = 3;
	localparam int DIM_W  = 8;
	localparam int CNT_W  = 8;   // up to 225 window pixels
	localparam int SUM_W  = 16;  // up to 225 * 255

	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic            op;
		logic [X_W-1:0]  pos_x;
		logic [Y_W-1:0]  pos_y;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            out_of_frame;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/ecbb_frame_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ecbb_frame_mem (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [ecbb_pkg::ADDR_W-1:0]  wr_addr,
	input  wire logic [ecbb_pkg::PIX_W-1:0]   wr_data,
	input  wire logic                         rd_en,
	input  wire logic [ecbb_pkg::ADDR_W-1:0]  rd_addr,
	output logic      [ecbb_pkg::PIX_W-1:0]   rd_data
);

	logic [ecbb_pkg::PIX_W-1:0] mem [ecbb_pkg::MAX_WIDTH*ecbb_pkg::MAX_HEIGHT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/ecbb_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module ecbb_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ecbb_pkg::SUM_W-1:0]  dividend,
	input  wire logic [ecbb_pkg::CNT_W-1:0]  divisor,
	output logic                             done,
	output logic      [ecbb_pkg::CH_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(ecbb_pkg::SUM_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [ecbb_pkg::SUM_W-1:0]  quo_q;
	logic [ecbb_pkg::CNT_W-1:0]  rem_q;
	logic [ecbb_pkg::CNT_W-1:0]  div_q;
	logic [ecbb_pkg::CNT_W:0]    trial;
	logic [ecbb_pkg::CNT_W:0]    diff;
	logic                        fits;

	assign trial = {rem_q, quo_q[ecbb_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ecbb_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ecbb_pkg::SUM_W-2:0], fits};
			rem_q <= fits ? diff[ecbb_pkg::CNT_W-1:0] : trial[ecbb_pkg::CNT_W-1:0];
		end
	end

	// the mean never exceeds a channel value, so the low bits hold it all
	assign done     = done_q;
	assign quotient = quo_q[ecbb_pkg::CH_W-1:0];

endmodule

`default_nettype wire

@@ rtl/edge_clipped_box_blur.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req (op, pos_x, pos_y, in_red/green/blue)
// rsp       out        rsp_valid / rsp_ready  rsp (out_red/green/blue, out_of_frame)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an in-frame write is stored as it is accepted; an out-of-frame query goes straight to ST_OUT
// an in-frame query does one frame memory read per window pixel
// (up to 225), then the shared 16-step divider runs once for each of three channels
// arst_n resets registers to radius 1 and a 128 x 128 frame; frame memory is not cleared
// the finished result sits in an output register so the next transaction is taken
// while it waits; a query result that finds it still full holds until rsp_ready

module edge_clipped_box_blur (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire ecbb_pkg::req_t               req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output ecbb_pkg::rsp_t                    rsp,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [ecbb_pkg::DIM_W-1:0]   cfg_data
);

	localparam int X_W = ecbb_pkg::X_W;
	localparam int Y_W = ecbb_pkg::Y_W;
	localparam int D_W = ecbb_pkg::DIM_W;

	ecbb_pkg::state_t state_q, state_nxt;

	logic [ecbb_pkg::RAD_W-1:0] radius_q;
	logic [D_W-1:0]             width_q;
	logic [D_W-1:0]             height_q;

	logic [X_W-1:0] x0_q, x1_q, cx_q;
	logic [Y_W-1:0] y1_q, cy_q;
	logic           rd_pend_q;
	logic [1:0]     ch_q;

	logic [ecbb_pkg::SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [ecbb_pkg::CNT_W-1:0] count_q;
	logic [ecbb_pkg::CH_W-1:0]  res_r_q, res_g_q, res_b_q;
	logic                       oof_q;

	logic           rsp_valid_q;
	ecbb_pkg::rsp_t rsp_q;

	logic [D_W-1:0]             w_eff, h_eff, x_ext, y_ext, r_ext, x_hi, y_hi;
	logic [ecbb_pkg::RAD_W-1:0] r_eff;
	logic                       in_frame, req_acc, is_query, scan_last, rsp_free;

	logic                        rd_en, div_start, div_done, load_rsp;
	logic [ecbb_pkg::PIX_W-1:0]  rd_data;
	logic [ecbb_pkg::SUM_W-1:0]  div_num;
	logic [ecbb_pkg::CH_W-1:0]   div_quo;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= ecbb_pkg::RAD_W'(1);
			width_q  <= D_W'(ecbb_pkg::MAX_WIDTH);
			height_q <= D_W'(ecbb_pkg::MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ecbb_pkg::CFG_RADIUS: radius_q <= cfg_data[ecbb_pkg::RAD_W-1:0];
				ecbb_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				ecbb_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp configuration to what the frame store holds, and the radius to 1 .. MAX_RADIUS
	always_comb begin
		w_eff = (width_q > D_W'(ecbb_pkg::MAX_WIDTH)) ? D_W'(ecbb_pkg::MAX_WIDTH) : width_q;
		h_eff = (height_q > D_W'(ecbb_pkg::MAX_HEIGHT)) ? D_W'(ecbb_pkg::MAX_HEIGHT) : height_q;
		if (radius_q == '0) begin
			r_eff = ecbb_pkg::RAD_W'(1);
		end else if (radius_q > ecbb_pkg::RAD_W'(ecbb_pkg::MAX_RADIUS)) begin
			r_eff = ecbb_pkg::RAD_W'(ecbb_pkg::MAX_RADIUS);
		end else begin
			r_eff = radius_q;
		end
		x_ext    = D_W'(req.pos_x);
		y_ext    = D_W'(req.pos_y);
		r_ext    = D_W'(r_eff);
		x_hi     = x_ext + r_ext;
		y_hi     = y_ext + r_ext;
		in_frame = (x_ext < w_eff) && (y_ext < h_eff);
	end

	assign req_acc   = req_valid && req_ready;
	assign is_query  = req.op == ecbb_pkg::OP_QUERY;
	assign scan_last = (cx_q == x1_q) && (cy_q == y1_q);
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecbb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ecbb_pkg::ST_IDLE: begin
				if (req_acc && is_query) begin
					state_nxt = in_frame ? ecbb_pkg::ST_SCAN : ecbb_pkg::ST_OUT;
				end
			end
			ecbb_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_nxt = ecbb_pkg::ST_DRAIN;
				end
			end
			ecbb_pkg::ST_DRAIN:   state_nxt = ecbb_pkg::ST_DIV_GO;
			ecbb_pkg::ST_DIV_GO:  state_nxt = ecbb_pkg::ST_DIV_WAIT;
			ecbb_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_nxt = (ch_q == ecbb_pkg::CH_BLUE) ? ecbb_pkg::ST_OUT
					                                        : ecbb_pkg::ST_DIV_GO;
				end
			end
			ecbb_pkg::ST_OUT: begin
				if (rsp_free) begin
					state_nxt = ecbb_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ecbb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ecbb_pkg::ST_IDLE:   req_ready = 1'b1;
			ecbb_pkg::ST_SCAN:   rd_en     = 1'b1;
			ecbb_pkg::ST_DIV_GO: div_start = 1'b1;
			ecbb_pkg::ST_OUT:    load_rsp  = rsp_free;
			default: ;
		endcase
	end

	// window bounds and scan position
	always_ff @(posedge clk) begin
		if (req_acc) begin
			x0_q <= (x_ext >= r_ext) ? X_W'(x_ext - r_ext) : '0;
			x1_q <= (x_hi < w_eff) ? X_W'(x_hi) : X_W'(w_eff - 1'b1);
			y1_q <= (y_hi < h_eff) ? Y_W'(y_hi) : Y_W'(h_eff - 1'b1);
			cx_q <= (x_ext >= r_ext) ? X_W'(x_ext - r_ext) : '0;
			cy_q <= (y_ext >= r_ext) ? Y_W'(y_ext - r_ext) : '0;
		end else if (rd_en) begin
			if (cx_q == x1_q) begin
				cx_q <= x0_q;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_en;
		end
	end

	ecbb_frame_mem u_mem (
		.clk     (clk),
		.wr_en   (req_acc && !is_query && in_frame),
		.wr_addr ({req.pos_y, req.pos_x}),
		.wr_data ({req.in_red, req.in_green, req.in_blue}),
		.rd_en   (rd_en),
		.rd_addr ({cy_q, cx_q}),
		.rd_data (rd_data)
	);

	// window sums, one pixel per cycle behind the memory read
	always_ff @(posedge clk) begin
		if (req_acc) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			count_q <= '0;
		end else if (rd_pend_q) begin
			sum_r_q <= sum_r_q + ecbb_pkg::SUM_W'(rd_data[23:16]);
			sum_g_q <= sum_g_q + ecbb_pkg::SUM_W'(rd_data[15:8]);
			sum_b_q <= sum_b_q + ecbb_pkg::SUM_W'(rd_data[7:0]);
			count_q <= count_q + 1'b1;
		end
	end

	always_comb begin
		case (ch_q)
			ecbb_pkg::CH_RED:   div_num = sum_r_q;
			ecbb_pkg::CH_GREEN: div_num = sum_g_q;
			default:            div_num = sum_b_q;
		endcase
	end

	ecbb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= ecbb_pkg::CH_RED;
		end else if (req_acc) begin
			ch_q <= ecbb_pkg::CH_RED;
		end else if (state_q == ecbb_pkg::ST_DIV_WAIT && div_done) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			res_r_q <= '0;
			res_g_q <= '0;
			res_b_q <= '0;
			oof_q   <= !in_frame;
		end else if (state_q == ecbb_pkg::ST_DIV_WAIT && div_done) begin
			case (ch_q)
				ecbb_pkg::CH_RED:   res_r_q <= div_quo;
				ecbb_pkg::CH_GREEN: res_g_q <= div_quo;
				default:            res_b_q <= div_quo;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.out_red      <= res_r_q;
			rsp_q.out_green    <= res_g_q;
			rsp_q.out_blue     <= res_b_q;
			rsp_q.out_of_frame <= oof_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ sim/tb_edge_clipped_box_blur.sv @@
`timescale 1ns / 1ps

module tb_edge_clipped_box_blur;

	localparam int CYCLE_LIMIT       = 2000000;
	localparam int DRAIN_CYCLES      = 300;   // full window of reads plus three divides
	localparam int HOLD_CYCLES       = 1500;
	localparam int REPORT_LINES      = 100;
	localparam int STEPS_PER_SETTING = 15;
	localparam int SETTINGS_PER_MODE = 3;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_ready;
	ecbb_pkg::req_t                req       = '0;
	logic                          rsp_valid;
	logic                          rsp_ready = 1'b0;
	ecbb_pkg::rsp_t                rsp;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index = ecbb_pkg::CFG_RADIUS;
	logic [ecbb_pkg::DIM_W-1:0]    cfg_data  = '0;

	// shadow of the block: stored frame and register values
	logic [ecbb_pkg::PIX_W-1:0] frame_px   [ecbb_pkg::MAX_WIDTH*ecbb_pkg::MAX_HEIGHT];
	bit                         px_written [ecbb_pkg::MAX_WIDTH*ecbb_pkg::MAX_HEIGHT];
	logic [ecbb_pkg::RAD_W-1:0] radius_reg = 3'd1;
	logic [ecbb_pkg::DIM_W-1:0] cols_reg   = 8'd128;
	logic [ecbb_pkg::DIM_W-1:0] rows_reg   = 8'd128;

	ecbb_pkg::rsp_t blur_expect [$];
	ecbb_pkg::rsp_t blur_head;

	int error_count   = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_go       = 1'b0;
	bit hold_seen     = 1'b0;
	int hold_left     = 0;

	edge_clipped_box_blur i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_edge_clipped_box_blur: errors");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold when the test toggles hold_go
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic int frame_cols();
		return (cols_reg > ecbb_pkg::MAX_WIDTH) ? ecbb_pkg::MAX_WIDTH : int'(cols_reg);
	endfunction

	function automatic int frame_rows();
		return (rows_reg > ecbb_pkg::MAX_HEIGHT) ? ecbb_pkg::MAX_HEIGHT : int'(rows_reg);
	endfunction

	function automatic int window_radius();
		int rad;
		rad = int'(radius_reg);
		if (rad < 1)
			rad = 1;
		if (rad > ecbb_pkg::MAX_RADIUS)
			rad = ecbb_pkg::MAX_RADIUS;
		return rad;
	endfunction

	function automatic void window_bounds(input int x, input int y, output int x0,
			output int x1, output int y0, output int y1);
		int rad;
		rad = window_radius();
		x0 = (x > rad) ? x - rad : 0;
		y0 = (y > rad) ? y - rad : 0;
		x1 = (x + rad < frame_cols()) ? x + rad : frame_cols() - 1;
		y1 = (y + rad < frame_rows()) ? y + rad : frame_rows() - 1;
	endfunction

	function automatic ecbb_pkg::rsp_t blur_at(input int x, input int y);
		int x0, x1, y0, y1, i, j, cnt, sum_r, sum_g, sum_b;
		logic [ecbb_pkg::PIX_W-1:0] px;
		ecbb_pkg::rsp_t res;
		res = '0;
		if (x >= frame_cols() || y >= frame_rows()) begin
			res.out_of_frame = 1'b1;
			return res;
		end
		window_bounds(x, y, x0, x1, y0, y1);
		cnt = 0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (j = y0; j <= y1; j++) begin
			for (i = x0; i <= x1; i++) begin
				px = frame_px[j*ecbb_pkg::MAX_WIDTH + i];
				sum_r += int'(px[23:16]);
				sum_g += int'(px[15:8]);
				sum_b += int'(px[7:0]);
				cnt++;
			end
		end
		res.out_red   = ecbb_pkg::CH_W'(sum_r / cnt);
		res.out_green = ecbb_pkg::CH_W'(sum_g / cnt);
		res.out_blue  = ecbb_pkg::CH_W'(sum_b / cnt);
		return res;
	endfunction

	// channel levels lean toward the extremes
	function automatic logic [ecbb_pkg::CH_W-1:0] rand_level();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return ecbb_pkg::CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic ecbb_pkg::req_t make_item(input logic op, input int x, input int y);
		ecbb_pkg::req_t item;
		item.op       = op;
		item.pos_x    = x[ecbb_pkg::X_W-1:0];
		item.pos_y    = y[ecbb_pkg::Y_W-1:0];
		item.in_red   = rand_level();
		item.in_green = rand_level();
		item.in_blue  = rand_level();
		return item;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= REPORT_LINES)
			$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (blur_expect.size() == 0) begin
				report_mismatch("result with nothing pending", int'(rsp), 0);
			end else begin
				blur_head = blur_expect.pop_front();
				if (rsp.out_red !== blur_head.out_red)
					report_mismatch("out_red", rsp.out_red, blur_head.out_red);
				if (rsp.out_green !== blur_head.out_green)
					report_mismatch("out_green", rsp.out_green, blur_head.out_green);
				if (rsp.out_blue !== blur_head.out_blue)
					report_mismatch("out_blue", rsp.out_blue, blur_head.out_blue);
				if (rsp.out_of_frame !== blur_head.out_of_frame)
					report_mismatch("out_of_frame", rsp.out_of_frame, blur_head.out_of_frame);
			end
		end
	end

	task automatic send_item(input ecbb_pkg::req_t item);
		int idx;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		idx = int'(item.pos_y) * ecbb_pkg::MAX_WIDTH + int'(item.pos_x);
		if (item.op == ecbb_pkg::OP_QUERY) begin
			blur_expect.push_back(blur_at(int'(item.pos_x), int'(item.pos_y)));
		end else if (int'(item.pos_x) < frame_cols() && int'(item.pos_y) < frame_rows()) begin
			frame_px[idx]   = {item.in_red, item.in_green, item.in_blue};
			px_written[idx] = 1'b1;
		end
	endtask

	// queries may only cover stored pixels, so write whatever the window still lacks
	task automatic query_at(input int x, input int y);
		int x0, x1, y0, y1, i, j;
		if (x < frame_cols() && y < frame_rows()) begin
			window_bounds(x, y, x0, x1, y0, y1);
			for (j = y0; j <= y1; j++)
				for (i = x0; i <= x1; i++)
					if (!px_written[j*ecbb_pkg::MAX_WIDTH + i])
						send_item(make_item(ecbb_pkg::OP_WRITE, i, j));
		end
		send_item(make_item(ecbb_pkg::OP_QUERY, x, y));
	endtask

	task automatic wait_settled(input int extra);
		@(negedge clk);
		req_valid <= 1'b0;
		while (blur_expect.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [ecbb_pkg::DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ecbb_pkg::CFG_RADIUS: radius_reg = val[ecbb_pkg::RAD_W-1:0];
			ecbb_pkg::CFG_WIDTH:  cols_reg   = val;
			ecbb_pkg::CFG_HEIGHT: rows_reg   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input int rad, input int cols, input int rows);
		logic [ecbb_pkg::DIM_W-1:0] val;
		wait_settled(DRAIN_CYCLES);
		val = ecbb_pkg::DIM_W'($urandom_range(255));
		val[ecbb_pkg::RAD_W-1:0] = rad[ecbb_pkg::RAD_W-1:0];
		write_reg(ecbb_pkg::CFG_RADIUS, val);
		write_reg(ecbb_pkg::CFG_WIDTH, cols[ecbb_pkg::DIM_W-1:0]);
		write_reg(ecbb_pkg::CFG_HEIGHT, rows[ecbb_pkg::DIM_W-1:0]);
	endtask

	task automatic test_reset_defaults();
		query_at(0, 0);
	endtask

	task automatic test_small_frame();
		int i, j;
		set_frame(0, 3, 2);
		for (j = 0; j < 2; j++)
			for (i = 0; i < 3; i++)
				send_item(make_item(ecbb_pkg::OP_WRITE, i, j));
		query_at(1, 0);
		query_at(2, 1);
		send_item(make_item(ecbb_pkg::OP_WRITE, 3, 0));
		query_at(3, 0);
		query_at(0, 2);
		query_at(127, 127);
		query_at(2, 0);
	endtask

	task automatic test_empty_frame();
		set_frame(1, 0, 2);
		query_at(0, 0);
		send_item(make_item(ecbb_pkg::OP_WRITE, 0, 0));
		set_frame(1, 3, 0);
		query_at(1, 1);
		// pixels stored before the frame was emptied come back unchanged
		set_frame(1, 3, 2);
		query_at(0, 0);
	endtask

	task automatic test_oversized_frame();
		set_frame(1, 255, 129);
		query_at(127, 127);
	endtask

	task automatic test_tiny_frame_wide_radius();
		set_frame(7, 1, 1);
		query_at(0, 0);
		query_at(1, 0);
	endtask

	task automatic test_saturated_window();
		ecbb_pkg::req_t item;
		int i, j;
		set_frame(7, 15, 15);
		for (j = 0; j < 15; j++) begin
			for (i = 0; i < 15; i++) begin
				item = make_item(ecbb_pkg::OP_WRITE, i, j);
				item.in_red   = 8'd255;
				item.in_green = 8'd255;
				item.in_blue  = 8'd255;
				send_item(item);
			end
		end
		query_at(7, 7);
		query_at(0, 0);
		query_at(14, 14);
		// one dark pixel in a full window of 225 must round the mean down
		item = make_item(ecbb_pkg::OP_WRITE, 7, 7);
		item.in_red   = 8'd0;
		item.in_green = 8'd0;
		item.in_blue  = 8'd0;
		send_item(item);
		query_at(7, 7);
	endtask

	task automatic pick_random_setting();
		int cols, rows;
		case ($urandom_range(9))
			0: begin
				cols = $urandom_range(255, 128);
				rows = $urandom_range(12, 1);
			end
			1: begin
				cols = $urandom_range(12, 1);
				rows = $urandom_range(255, 128);
			end
			2: begin
				cols = 128;
				rows = 128;
			end
			3: begin
				cols = 0;
				rows = $urandom_range(12, 1);
			end
			4: begin
				cols = $urandom_range(12, 1);
				rows = 0;
			end
			default: begin
				cols = $urandom_range(16, 1);
				rows = $urandom_range(16, 1);
			end
		endcase
		// large frames keep the window small so the pixel fill stays short
		if (cols * rows > 400)
			set_frame($urandom_range(1), cols, rows);
		else
			set_frame($urandom_range(7), cols, rows);
	endtask

	task automatic random_step();
		int cols, rows, pick;
		cols = frame_cols();
		rows = frame_rows();
		pick = $urandom_range(99);
		if (pick < 35 && cols > 0 && rows > 0)
			send_item(make_item(ecbb_pkg::OP_WRITE, $urandom_range(cols - 1),
				$urandom_range(rows - 1)));
		else if (pick < 45)
			send_item(make_item(ecbb_pkg::OP_WRITE, $urandom_range(127), $urandom_range(127)));
		else if (pick < 85 && cols > 0 && rows > 0)
			query_at($urandom_range(cols - 1), $urandom_range(rows - 1));
		else
			query_at($urandom_range(127), $urandom_range(127));
	endtask

	task automatic test_random(input int send_pct, input int recv_pct);
		int s, k;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (s = 0; s < SETTINGS_PER_MODE; s++) begin
			pick_random_setting();
			for (k = 0; k < STEPS_PER_SETTING; k++)
				random_step();
		end
	endtask

	task automatic test_backpressure();
		int k;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_frame(2, 6, 5);
		query_at(0, 0);
		// receiver blocks long enough for the result register and the input to back up
		hold_go = !hold_go;
		for (k = 0; k < 8; k++)
			query_at($urandom_range(5), $urandom_range(4));
		wait_settled(0);
		for (k = 0; k < 4; k++)
			query_at($urandom_range(5), $urandom_range(4));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 11;
		recv_idle_pct = 64;
		test_reset_defaults();
		test_small_frame();
		test_empty_frame();
		test_oversized_frame();
		test_tiny_frame_wide_radius();
		test_saturated_window();
		test_random(11, 64);
		test_random(64, 11);
		test_random(0, 0);
		test_backpressure();
		wait_settled(DRAIN_CYCLES);
		if (error_count == 0)
			$display("tb_edge_clipped_box_blur: clean");
		else
			$display("tb_edge_clipped_box_blur: errors");
		$finish;
	end

endmodule
